// File: rtl/core/ptw_pkg.sv
// Shared types, constants and control words for the four-level page-table walker.
package ptw_pkg;

  // Table memory geometry; the depth must be a power of two.
  localparam int unsigned TABLE_WORDS = 4096;
  localparam int unsigned WORD_AW     = $clog2(TABLE_WORDS);
  localparam int unsigned IDX_W       = 9;

  // Table entry fields
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_HUGE    = 7;
  localparam int unsigned ADDR_LO     = 12;
  localparam int unsigned ADDR_HI     = 51;
  localparam int unsigned PHYS_W      = 53;

  // Walk levels, numbered so that the index field starts at 12 + 9 * level
  localparam logic [1:0] LVL_L1 = 2'd0;
  localparam logic [1:0] LVL_L2 = 2'd1;
  localparam logic [1:0] LVL_L3 = 2'd2;
  localparam logic [1:0] LVL_L4 = 2'd3;

  // Page size codes
  localparam logic [1:0] PS_4K   = 2'd0;
  localparam logic [1:0] PS_2M   = 2'd1;
  localparam logic [1:0] PS_1G   = 2'd2;
  localparam logic [1:0] PS_NONE = 2'd3;

  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] word_index;
    logic [63:0] word_value;
    logic [51:0] root_table;
    logic [47:0] lin_addr;
  } ptw_req_t;

  typedef struct packed {
    logic [52:0] xlat_addr;
    logic        mapped;
    logic [1:0]  pg_size;
  } ptw_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } ptw_state_e;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_FAULT,
    FIN_1G,
    FIN_2M,
    FIN_4K
  } ptw_fin_e;

  // Controller to datapath
  typedef struct packed {
    logic       wr;       // store the request word into table memory
    logic       capture;  // take the request: address from root, latch virtual address
    logic [1:0] idx_lvl;  // level whose index forms the next read address
    ptw_fin_e   fin;      // end the walk with this outcome
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic present;
    logic huge;
  } ptw_sts_t;

endpackage

// File: rtl/core/ptw_ram.sv
// Generic single-port RAM with registered read data.
module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ptw_datapath.sv
// Walker datapath: table memory, read address forming and result register.
module ptw_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptw_pkg::ptw_req_t req_i,
  input  ptw_pkg::ptw_cmd_t cmd_i,
  output ptw_pkg::ptw_sts_t sts_o,
  output ptw_pkg::ptw_res_t res_o,
  output logic              res_valid_o
);

  localparam logic [ptw_pkg::WORD_AW-1:0] IdxMask = ptw_pkg::WORD_AW'((1 << ptw_pkg::IDX_W) - 1);

  logic [47:0]                   virt_q;
  logic [63:0]                   entry;
  logic [51:0]                   base;
  logic [47:0]                   virt_sel;
  logic [ptw_pkg::IDX_W-1:0]     idx;
  logic [ptw_pkg::WORD_AW-1:0]   walk_addr;
  logic [ptw_pkg::WORD_AW-1:0]   ram_addr;
  logic [29:0]                   offset;
  logic [ptw_pkg::PHYS_W-1:0]    page_base;
  ptw_pkg::ptw_res_t             res_d, res_q;
  logic                          res_valid_q;

  ptw_ram #(
    .WIDTH (64),
    .DEPTH (ptw_pkg::TABLE_WORDS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .addr_i  (ram_addr),
    .wdata_i (req_i.word_value),
    .rdata_o (entry)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      virt_q <= req_i.lin_addr;
    end
  end

  // Table base is 4 KB aligned, so its word bits below the index are zero
  always_comb begin
    if (cmd_i.capture) begin
      base     = {req_i.root_table[51:12], 12'h000};
      virt_sel = req_i.lin_addr;
    end else begin
      base     = {entry[ptw_pkg::ADDR_HI:ptw_pkg::ADDR_LO], 12'h000};
      virt_sel = virt_q;
    end
    case (cmd_i.idx_lvl)
      ptw_pkg::LVL_L4: idx = virt_sel[47:39];
      ptw_pkg::LVL_L3: idx = virt_sel[38:30];
      ptw_pkg::LVL_L2: idx = virt_sel[29:21];
      default:         idx = virt_sel[20:12];
    endcase
    walk_addr = (base[ptw_pkg::WORD_AW+2:3] & ~IdxMask) | ptw_pkg::WORD_AW'(idx);
    if (cmd_i.wr) begin
      ram_addr = ptw_pkg::WORD_AW'(req_i.word_index);
    end else begin
      ram_addr = walk_addr;
    end
  end

  assign sts_o.present = entry[ptw_pkg::BIT_PRESENT];
  assign sts_o.huge    = entry[ptw_pkg::BIT_HUGE];

  assign page_base = {1'b0, entry[ptw_pkg::ADDR_HI:ptw_pkg::ADDR_LO], 12'h000};

  always_comb begin
    offset = '0;
    res_d  = '0;
    case (cmd_i.fin)
      ptw_pkg::FIN_1G: begin
        offset        = virt_q[29:0];
        res_d.pg_size = ptw_pkg::PS_1G;
        res_d.mapped  = 1'b1;
      end
      ptw_pkg::FIN_2M: begin
        offset        = {9'h000, virt_q[20:0]};
        res_d.pg_size = ptw_pkg::PS_2M;
        res_d.mapped  = 1'b1;
      end
      ptw_pkg::FIN_4K: begin
        offset        = {18'h00000, virt_q[11:0]};
        res_d.pg_size = ptw_pkg::PS_4K;
        res_d.mapped  = 1'b1;
      end
      default: begin
        res_d.pg_size = ptw_pkg::PS_NONE;
        res_d.mapped  = 1'b0;
      end
    endcase
    if (res_d.mapped) begin
      res_d.xlat_addr = page_base + ptw_pkg::PHYS_W'(offset);
    end else begin
      res_d.xlat_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin != ptw_pkg::FIN_NONE) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.fin != ptw_pkg::FIN_NONE);
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: rtl/core/ptw_ctrl.sv
// Walker controller: accepts requests and steps through the table levels.
module ptw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              mode_i,
  input  ptw_pkg::ptw_sts_t sts_i,
  output logic              busy_o,
  output ptw_pkg::ptw_cmd_t cmd_o
);

  ptw_pkg::ptw_state_e state_d, state_q;
  logic [1:0]          level_d, level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptw_pkg::ST_IDLE;
      level_q <= ptw_pkg::LVL_L4;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    level_d       = level_q;
    busy_o        = 1'b0;
    cmd_o.wr      = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.idx_lvl = ptw_pkg::LVL_L4;
    cmd_o.fin     = ptw_pkg::FIN_NONE;
    unique case (state_q)
      ptw_pkg::ST_IDLE: begin
        if (start_i) begin
          if (mode_i == ptw_pkg::MODE_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            level_d       = ptw_pkg::LVL_L4;
            state_d       = ptw_pkg::ST_WALK;
          end
        end
      end
      ptw_pkg::ST_WALK: begin
        busy_o        = 1'b1;
        cmd_o.idx_lvl = level_q - 2'd1;
        if (!sts_i.present) begin
          cmd_o.fin = ptw_pkg::FIN_FAULT;
        end else if (level_q == ptw_pkg::LVL_L3 && sts_i.huge) begin
          cmd_o.fin = ptw_pkg::FIN_1G;
        end else if (level_q == ptw_pkg::LVL_L2 && sts_i.huge) begin
          cmd_o.fin = ptw_pkg::FIN_2M;
        end else if (level_q == ptw_pkg::LVL_L1) begin
          cmd_o.fin = ptw_pkg::FIN_4K;
        end else begin
          level_d = level_q - 2'd1;
        end
        if (cmd_o.fin != ptw_pkg::FIN_NONE) begin
          state_d = ptw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/four_level_page_table_walker.sv
// Top level of the four-level page-table walker.
//
// Usage: drive a request word on req_i and raise start; the word is taken at a
// rising edge where start is high and busy is low.
// A write word (mode 0) stores word_value into table memory word word_index at
// that edge. It yields no result and leaves busy low, so requests may follow
// in every cycle.
// A translate word (mode 1) raises busy and walks up to four levels, one table
// memory read per cycle through the single RAM port. The result shows on res_o
// with res_valid_o high for exactly one cycle and is taken at the edge ending
// that cycle. The walk reads the level-4 entry first and ends on an absent
// entry; a level-3 entry ends it on a 1 GB page or a fault, a level-2 entry
// on a 2 MB page or a fault, and a level-1 entry on a 4 KB page or a fault.
// Busy drops in that result cycle, so a new word can be taken there; the
// dependent memory reads set how soon a translation can follow the last.
// The receiver cannot stall: a result not taken in its cycle is gone.
// Reset clears the controller and the result strobe; table memory is not
// cleared, and a walk that reads a never-written word gives an undefined answer.
module four_level_page_table_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ptw_pkg::ptw_req_t req_i,
  output ptw_pkg::ptw_res_t res_o,
  output logic              res_valid_o
);

  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  // Sequence the walk: accept, pick the next level, decide when it ends
  ptw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (req_i.mode),
    .sts_i   (sts),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // Hold the table memory, form read addresses and build the result word
  ptw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // A result always ends a walk: the walker was busy and is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a walk");

  // An accepted translate word starts a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.mode == ptw_pkg::MODE_TRANSLATE) |=> busy)
    else $error("translate word accepted without starting a walk");

  // Unmapped results carry zero address and no page size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.mapped) |->
      (res_o.xlat_addr == '0 && res_o.pg_size == ptw_pkg::PS_NONE))
    else $error("unmapped result with address or page size");

  // Mapped results never report the no-page code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.mapped) |-> (res_o.pg_size != ptw_pkg::PS_NONE))
    else $error("mapped result without page size");

endmodule
